// ===== hdl/iap_pkg.sv =====
// Package for the integer ALU with power unit: codes, types and shared constants.
package iap_pkg;

  // Default operand width
  localparam int WIDTH_DEF = 32;

  // Multiplier digit: bits of the multiplier consumed per step
  localparam int MUL_DIGIT = 8;

  // Operation codes
  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;
  localparam logic [2:0] MODE_POW  = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEG_EXP  = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_MUL_END,
    S_DIV,
    S_DIV_END,
    S_POW_CHECK,
    S_POW_MUL,
    S_POW_UPD,
    S_DONE
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_QUICK,
    DP_MUL_STEP,
    DP_MUL_DONE,
    DP_DIV_STEP,
    DP_DIV_FIX,
    DP_POW_SETUP,
    DP_POW_UPD,
    DP_POW_DONE,
    DP_LOAD_OUT
  } dp_op_t;

  // Command from controller to datapath
  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic need_pow;
    logic mul_last;
    logic div_last;
    logic expo_zero;
  } dp_status_t;

endpackage

// ===== hdl/iap_dp.sv =====
// Datapath: operand registers, digit-serial multiplier lanes, restoring divider, output word.
module iap_dp #(
  parameter int WIDTH = iap_pkg::WIDTH_DEF
) (
  input  logic                    clk,
  input  iap_pkg::dp_cmd_t        cmd,
  output iap_pkg::dp_status_t     st,
  input  logic [2:0]              in_mode,
  input  logic signed [WIDTH-1:0] in_lhs,
  input  logic signed [WIDTH-1:0] in_rhs,
  output logic signed [WIDTH-1:0] out_value,
  output logic [1:0]              out_status
);

  localparam int DIG   = iap_pkg::MUL_DIGIT;
  localparam int STEPS = (WIDTH + DIG - 1) / DIG;
  localparam int CNT_W = $clog2(WIDTH);

  // Operands
  logic [2:0]       mode_r, mode_nxt;
  logic [WIDTH-1:0] lhs_r, lhs_nxt;
  logic [WIDTH-1:0] rhs_r, rhs_nxt;

  // Multiplier lanes: lane 0 is the product, lane 1 the squaring of the base
  logic [WIDTH-1:0] ma0_r, ma0_nxt, mb0_r, mb0_nxt, prod0_r, prod0_nxt;
  logic [WIDTH-1:0] ma1_r, ma1_nxt, mb1_r, mb1_nxt, prod1_r, prod1_nxt;

  // Power state
  logic [WIDTH-1:0] acc_r, acc_nxt, base_r, base_nxt, expo_r, expo_nxt;

  // Divider state
  logic [WIDTH-1:0] dq_r, dq_nxt, dv_r, dv_nxt, rem_r, rem_nxt;
  logic             neg_r, neg_nxt;

  // Shared step counter
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Result and output word
  logic [WIDTH-1:0] res_r, res_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [WIDTH-1:0] out_value_r, out_value_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  // Combinational helpers
  logic [WIDTH+DIG-1:0] pp0, pp1;
  logic [WIDTH-1:0]     lhs_mag, rhs_mag;
  logic [WIDTH:0]       div_sh;
  logic [WIDTH:0]       div_diff;
  logic                 div_ge;

  // Partial products, one multiplier digit each
  assign pp0 = {{DIG{1'b0}}, ma0_r} * {{WIDTH{1'b0}}, mb0_r[DIG-1:0]};
  assign pp1 = {{DIG{1'b0}}, ma1_r} * {{WIDTH{1'b0}}, mb1_r[DIG-1:0]};

  // Magnitudes of the operands
  assign lhs_mag = lhs_r[WIDTH-1] ? (~lhs_r + 1'b1) : lhs_r;
  assign rhs_mag = rhs_r[WIDTH-1] ? (~rhs_r + 1'b1) : rhs_r;

  // Restoring division trial subtract
  assign div_sh   = {rem_r, dq_r[WIDTH-1]};
  assign div_ge   = div_sh >= {1'b0, dv_r};
  assign div_diff = div_sh - {1'b0, dv_r};

  // Status to the controller
  assign st.need_mul  = (mode_r == iap_pkg::MODE_MUL);
  assign st.need_div  = (mode_r == iap_pkg::MODE_DIV) && (rhs_r != '0);
  assign st.need_pow  = (mode_r == iap_pkg::MODE_POW) && !rhs_r[WIDTH-1];
  assign st.mul_last  = (cnt_r == CNT_W'(STEPS - 1));
  assign st.div_last  = (cnt_r == CNT_W'(WIDTH - 1));
  assign st.expo_zero = (expo_r == '0);

  // Next-state logic per command
  always_comb begin
    mode_nxt       = mode_r;
    lhs_nxt        = lhs_r;
    rhs_nxt        = rhs_r;
    ma0_nxt        = ma0_r;
    mb0_nxt        = mb0_r;
    prod0_nxt      = prod0_r;
    ma1_nxt        = ma1_r;
    mb1_nxt        = mb1_r;
    prod1_nxt      = prod1_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    expo_nxt       = expo_r;
    dq_nxt         = dq_r;
    dv_nxt         = dv_r;
    rem_nxt        = rem_r;
    neg_nxt        = neg_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    stat_nxt       = stat_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    case (cmd.op)
      iap_pkg::DP_CAPTURE: begin
        mode_nxt = in_mode;
        lhs_nxt  = in_lhs;
        rhs_nxt  = in_rhs;
      end

      // Results of add, subtract and the error cases, plus setup of every iterative unit
      iap_pkg::DP_QUICK: begin
        stat_nxt = iap_pkg::ST_OK;
        case (mode_r)
          iap_pkg::MODE_ADD: res_nxt = lhs_r + rhs_r;
          iap_pkg::MODE_SUB: res_nxt = lhs_r - rhs_r;
          iap_pkg::MODE_DIV: begin
            res_nxt = lhs_r;
            if (rhs_r == '0) begin
              res_nxt  = '0;
              stat_nxt = iap_pkg::ST_DIV_ZERO;
            end
          end
          iap_pkg::MODE_POW: begin
            res_nxt = lhs_r;
            if (rhs_r[WIDTH-1]) begin
              res_nxt  = '0;
              stat_nxt = iap_pkg::ST_NEG_EXP;
            end
          end
          default: res_nxt = lhs_r;
        endcase
        ma0_nxt   = lhs_r;
        mb0_nxt   = rhs_r;
        prod0_nxt = '0;
        acc_nxt   = WIDTH'(1);
        base_nxt  = lhs_r;
        expo_nxt  = rhs_r;
        dq_nxt    = lhs_mag;
        dv_nxt    = rhs_mag;
        rem_nxt   = '0;
        neg_nxt   = lhs_r[WIDTH-1] ^ rhs_r[WIDTH-1];
        cnt_nxt   = '0;
      end

      // One digit on both lanes
      iap_pkg::DP_MUL_STEP: begin
        prod0_nxt = prod0_r + pp0[WIDTH-1:0];
        prod1_nxt = prod1_r + pp1[WIDTH-1:0];
        ma0_nxt   = ma0_r << DIG;
        ma1_nxt   = ma1_r << DIG;
        mb0_nxt   = mb0_r >> DIG;
        mb1_nxt   = mb1_r >> DIG;
        cnt_nxt   = cnt_r + 1'b1;
      end

      iap_pkg::DP_MUL_DONE: res_nxt = prod0_r;

      // One quotient bit
      iap_pkg::DP_DIV_STEP: begin
        if (div_ge) begin
          rem_nxt = div_diff[WIDTH-1:0];
          dq_nxt  = {dq_r[WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[WIDTH-1:0];
          dq_nxt  = {dq_r[WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end

      iap_pkg::DP_DIV_FIX: res_nxt = neg_r ? (~dq_r + 1'b1) : dq_r;

      // Load both lanes for acc*base and base*base
      iap_pkg::DP_POW_SETUP: begin
        ma0_nxt   = acc_r;
        mb0_nxt   = base_r;
        ma1_nxt   = base_r;
        mb1_nxt   = base_r;
        prod0_nxt = '0;
        prod1_nxt = '0;
        cnt_nxt   = '0;
      end

      iap_pkg::DP_POW_UPD: begin
        if (expo_r[0]) begin
          acc_nxt = prod0_r;
        end
        base_nxt = prod1_r;
        expo_nxt = expo_r >> 1;
      end

      iap_pkg::DP_POW_DONE: res_nxt = acc_r;

      iap_pkg::DP_LOAD_OUT: begin
        out_value_nxt  = res_r;
        out_status_nxt = stat_r;
      end

      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    lhs_r        <= lhs_nxt;
    rhs_r        <= rhs_nxt;
    ma0_r        <= ma0_nxt;
    mb0_r        <= mb0_nxt;
    prod0_r      <= prod0_nxt;
    ma1_r        <= ma1_nxt;
    mb1_r        <= mb1_nxt;
    prod1_r      <= prod1_nxt;
    acc_r        <= acc_nxt;
    base_r       <= base_nxt;
    expo_r       <= expo_nxt;
    dq_r         <= dq_nxt;
    dv_r         <= dv_nxt;
    rem_r        <= rem_nxt;
    neg_r        <= neg_nxt;
    cnt_r        <= cnt_nxt;
    res_r        <= res_nxt;
    stat_r       <= stat_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ===== hdl/iap_ctrl.sv =====
// Controller: sequences one operation at a time and owns the handshakes.
module iap_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  iap_pkg::dp_status_t st,
  output iap_pkg::dp_cmd_t    cmd
);

  iap_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iap_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.op        = iap_pkg::DP_NOP;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      iap_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = iap_pkg::DP_CAPTURE;
          state_nxt = iap_pkg::S_DECODE;
        end
      end

      iap_pkg::S_DECODE: begin
        cmd.op = iap_pkg::DP_QUICK;
        if (st.need_mul) begin
          state_nxt = iap_pkg::S_MUL;
        end else if (st.need_div) begin
          state_nxt = iap_pkg::S_DIV;
        end else if (st.need_pow) begin
          state_nxt = iap_pkg::S_POW_CHECK;
        end else begin
          state_nxt = iap_pkg::S_DONE;
        end
      end

      iap_pkg::S_MUL: begin
        cmd.op = iap_pkg::DP_MUL_STEP;
        if (st.mul_last) begin
          state_nxt = iap_pkg::S_MUL_END;
        end
      end

      iap_pkg::S_MUL_END: begin
        cmd.op    = iap_pkg::DP_MUL_DONE;
        state_nxt = iap_pkg::S_DONE;
      end

      iap_pkg::S_DIV: begin
        cmd.op = iap_pkg::DP_DIV_STEP;
        if (st.div_last) begin
          state_nxt = iap_pkg::S_DIV_END;
        end
      end

      iap_pkg::S_DIV_END: begin
        cmd.op    = iap_pkg::DP_DIV_FIX;
        state_nxt = iap_pkg::S_DONE;
      end

      // Stop once the exponent has no bits left
      iap_pkg::S_POW_CHECK: begin
        if (st.expo_zero) begin
          cmd.op    = iap_pkg::DP_POW_DONE;
          state_nxt = iap_pkg::S_DONE;
        end else begin
          cmd.op    = iap_pkg::DP_POW_SETUP;
          state_nxt = iap_pkg::S_POW_MUL;
        end
      end

      iap_pkg::S_POW_MUL: begin
        cmd.op = iap_pkg::DP_MUL_STEP;
        if (st.mul_last) begin
          state_nxt = iap_pkg::S_POW_UPD;
        end
      end

      iap_pkg::S_POW_UPD: begin
        cmd.op    = iap_pkg::DP_POW_UPD;
        state_nxt = iap_pkg::S_POW_CHECK;
      end

      // Hand the word to the output register once it is free
      iap_pkg::S_DONE: begin
        if (out_free) begin
          cmd.op        = iap_pkg::DP_LOAD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = iap_pkg::S_IDLE;
        end
      end

      default: state_nxt = iap_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // An accepted word always goes to decode next
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == iap_pkg::S_DECODE)
    else $error("accepted word did not enter decode");

  // Finishing loads a valid result and returns to idle
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == iap_pkg::S_DONE && out_free |=> out_valid_r && state_r == iap_pkg::S_IDLE)
    else $error("result not delivered on finish");

  // At most one iterative unit is requested per operation
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == iap_pkg::S_DECODE |-> $onehot0({st.need_mul, st.need_div, st.need_pow}))
    else $error("more than one unit requested");

  // Division keeps stepping until its last bit
  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == iap_pkg::S_DIV && !st.div_last |=> state_r == iap_pkg::S_DIV)
    else $error("division left early");
`endif

endmodule

// ===== hdl/integer_alu_with_power_unit.sv =====
// Top level of the integer ALU with power unit: controller plus datapath.
// Accepts one word at a time {mode, lhs, rhs} and returns {value, status}; arithmetic wraps
// modulo 2^WIDTH. Add, subtract, pass-through and the error cases (divide by zero, negative
// exponent) are settled at decode and then wait only for the output register. Multiply uses
// a digit-serial multiplier of 8 bits per cycle. Divide is a restoring divider, one quotient
// bit per cycle, with a sign fix at the end. Power runs square-and-multiply; each exponent
// bit up to the highest set bit costs a setup, one pass of the two multiplier lanes and an
// update. A new word is accepted the cycle after the previous result enters the output
// register, while that result waits to be taken.
module integer_alu_with_power_unit #(
  parameter int WIDTH = iap_pkg::WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_mode,
  input  logic signed [WIDTH-1:0] in_lhs,
  input  logic signed [WIDTH-1:0] in_rhs,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [WIDTH-1:0] out_value,
  output logic [1:0]              out_status
);

  iap_pkg::dp_cmd_t    cmd;
  iap_pkg::dp_status_t st;

  // Sequencer
  iap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Arithmetic
  iap_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .st         (st),
    .in_mode    (in_mode),
    .in_lhs     (in_lhs),
    .in_rhs     (in_rhs),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
